// File: rtl/core/cfpo_pkg.sv
// Package with the word types, codes and constants of the convex frame outside test.
package cfpo_pkg;
    localparam int MAX_CORNERS_DEF = 8;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FIELD_WIDTH = 16;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_FINALIZE = 2'd1,
        CMD_QUERY    = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_FRAME = 2'd1,
        ST_FEW       = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]              command;
        logic [2:0]              corner_index;
        logic signed [FIELD_WIDTH-1:0] x_coord;
        logic signed [FIELD_WIDTH-1:0] y_coord;
    } t_in_word;

    typedef struct packed {
        logic       outside;
        logic [1:0] status;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EDGE,
        S_MUL,
        S_CMP,
        S_DONE
    } t_state;
endpackage

// File: rtl/core/cfpo_front.sv
// Front part: accepts input words and holds them in a short queue for the back part.
module cfpo_front import cfpo_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_word i_word,
    output logic     o_q_valid,
    input  logic     i_q_take,
    output t_in_word o_q_word
);
    t_in_word r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic push;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_word  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(i_q_take && o_q_valid);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_word;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_take && o_q_valid) r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    property p_no_take_empty;
        @(posedge i_clk) disable iff (!i_rst_n) i_q_take |-> o_q_valid;
    endproperty
    a_no_take_empty: assert property (p_no_take_empty) else $error("take from empty queue");

    property p_full_stalls;
        @(posedge i_clk) disable iff (!i_rst_n) (r_cnt == 2'd2) |-> o_stall;
    endproperty
    a_full_stalls: assert property (p_full_stalls) else $error("full queue not stalling");

    property p_cnt_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3;
    endproperty
    a_cnt_range: assert property (p_cnt_range) else $error("queue count overflow");
endmodule

// File: rtl/core/cfpo_back.sv
// Back part: corner store, side flags and the edge-by-edge sequencer for finalize and query.
module cfpo_back import cfpo_pkg::*; #(
    parameter int MAX_CORNERS = MAX_CORNERS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [3:0] i_corner_count,
    input  logic      i_q_valid,
    output logic      o_q_take,
    input  t_in_word  i_q_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word,
    output logic      o_busy
);
    localparam int IW = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int CW = IW + 1;

    logic signed [COORD_WIDTH-1:0] r_xs [MAX_CORNERS];
    logic signed [COORD_WIDTH-1:0] r_ys [MAX_CORNERS];
    logic [MAX_CORNERS-1:0] r_flag, n_flag, r_nf, n_nf;

    t_state r_state, n_state;
    t_in_word r_cmd, n_cmd;
    logic [IW-1:0] r_i, n_i, r_j, n_j;
    logic [CW-1:0] r_hi, n_hi, r_lo, n_lo;
    logic signed [COORD_WIDTH-1:0] r_x0, r_y0, r_x1, r_y1, r_px, r_py;
    logic signed [COORD_WIDTH-1:0] n_x0, n_y0, n_x1, n_y1, n_px, n_py;
    logic signed [DW-1:0] r_a, r_b, r_c, r_d, n_a, n_b, n_c, n_d;
    logic r_vert, r_horz, r_dxpos, n_vert, n_horz, n_dxpos;
    logic signed [PW-1:0] r_p, r_q;
    logic r_ov, n_ov;
    t_out_word r_out, n_out;
    logic r_ovalid, n_ovalid;

    logic [IW-1:0] i1, nlast;
    logic [3:0] cnt;
    logic signed [DW-1:0] dx, dy;
    logic signed [1:0] s, side;
    logic skip, last_j, last_i;
    logic signed [COORD_WIDTH-1:0] qx, qy;

    assign cnt   = i_corner_count;
    assign nlast = IW'(cnt - 4'd1);
    assign i1    = (r_i == nlast) ? '0 : r_i + 1'b1;
    assign qx    = COORD_WIDTH'(i_q_word.x_coord);
    assign qy    = COORD_WIDTH'(i_q_word.y_coord);
    assign o_valid = r_ovalid;
    assign o_word  = r_out;
    assign o_busy  = (r_state != S_IDLE) || r_ovalid;
    assign o_q_take = (r_state == S_IDLE) && i_q_valid && !(r_ovalid && i_stall);

    always_comb begin
        dx = DW'(r_x1) - DW'(r_x0);
        dy = DW'(r_y1) - DW'(r_y0);
        if (r_vert)      s = (r_a > 0) ? 2'sd1 : ((r_a < 0) ? -2'sd1 : 2'sd0);
        else if (r_horz) s = (r_b > 0) ? 2'sd1 : ((r_b < 0) ? -2'sd1 : 2'sd0);
        else             s = (r_p > r_q) ? 2'sd1 : ((r_p < r_q) ? -2'sd1 : 2'sd0);
        side = (r_vert || r_horz || r_dxpos) ? s : -s;
    end

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_i = r_i; n_j = r_j;
        n_hi = r_hi; n_lo = r_lo; n_x0 = r_x0; n_y0 = r_y0; n_x1 = r_x1;
        n_y1 = r_y1; n_px = r_px; n_py = r_py; n_a = r_a; n_b = r_b;
        n_c = r_c; n_d = r_d; n_vert = r_vert; n_horz = r_horz;
        n_dxpos = r_dxpos; n_ov = r_ov; n_flag = r_flag; n_nf = r_nf;
        n_out = r_out; n_ovalid = r_ovalid && i_stall;
        skip = 1'b0; last_j = 1'b0; last_i = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (o_q_take) begin
                    n_cmd = i_q_word;
                    n_px = qx; n_py = qy;
                    n_i = '0; n_j = '0; n_hi = '0; n_lo = '0; n_ov = 1'b0;
                    n_nf = r_flag;
                    n_out = '{outside: 1'b0, status: ST_OK};
                    priority if (i_q_word.command == CMD_LOAD) begin
                        if (32'(i_q_word.corner_index) >= MAX_CORNERS)
                            n_out.status = ST_RANGE;
                        n_ovalid = 1'b1;
                    end else if (i_q_word.command == CMD_NONE) begin
                        n_ovalid = 1'b1;
                    end else if (cnt < 4'd3) begin
                        n_out.status = ST_FEW; n_ovalid = 1'b1;
                    end else if (32'(cnt) > MAX_CORNERS) begin
                        n_out.status = ST_RANGE; n_ovalid = 1'b1;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_x0 = r_xs[r_i]; n_y0 = r_ys[r_i];
                n_x1 = r_xs[i1];  n_y1 = r_ys[i1];
                if (r_cmd.command == CMD_FINALIZE) begin
                    n_px = r_xs[r_j]; n_py = r_ys[r_j];
                end
                n_state = S_EDGE;
            end
            S_EDGE: begin
                n_vert  = (dx == 0);
                n_horz  = (dy == 0);
                n_dxpos = (dx > 0);
                n_a = DW'(r_px) - DW'(r_x0);
                n_b = DW'(r_py) - DW'(r_y0);
                n_c = dx; n_d = dy;
                n_state = S_MUL;
            end
            S_MUL: n_state = S_CMP;
            S_CMP: begin
                if (r_cmd.command == CMD_QUERY) begin
                    last_i = (r_i == nlast);
                    if ((!r_flag[r_i] && side > 0) || (r_flag[r_i] && side < 0)) begin
                        n_out.outside = 1'b1; n_state = S_DONE;
                    end else if (last_i) begin
                        n_state = S_DONE;
                    end else begin
                        n_i = r_i + 1'b1; n_state = S_FETCH;
                    end
                end else begin
                    skip = (r_j == r_i) || (r_j == i1);
                    if (!skip && side > 0) n_hi = r_hi + 1'b1;
                    if (!skip && side < 0) n_lo = r_lo + 1'b1;
                    last_j = (r_j == nlast);
                    n_state = S_FETCH;
                    if (!last_j) begin
                        n_j = r_j + 1'b1;
                    end else begin
                        last_i = (r_i == nlast);
                        if (CW'(n_hi) + CW'(2) == CW'(cnt))      n_nf[r_i] = 1'b1;
                        else if (CW'(n_lo) + CW'(2) == CW'(cnt)) n_nf[r_i] = 1'b0;
                        else n_ov = 1'b1;
                        n_j = '0; n_hi = '0; n_lo = '0;
                        if (n_ov) begin
                            n_out.status = ST_BAD_FRAME; n_state = S_DONE;
                        end else if (last_i) begin
                            n_flag = n_nf; n_state = S_DONE;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!(r_ovalid && i_stall)) begin
                    n_ovalid = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_take && i_q_word.command == CMD_LOAD
                && 32'(i_q_word.corner_index) < MAX_CORNERS) begin
            r_xs[IW'(i_q_word.corner_index)] <= qx;
            r_ys[IW'(i_q_word.corner_index)] <= qy;
        end
        r_p <= PW'(r_b) * PW'(r_c);
        r_q <= PW'(r_a) * PW'(r_d);
        r_cmd <= n_cmd; r_i <= n_i; r_j <= n_j; r_hi <= n_hi; r_lo <= n_lo;
        r_x0 <= n_x0; r_y0 <= n_y0; r_x1 <= n_x1; r_y1 <= n_y1;
        r_px <= n_px; r_py <= n_py; r_a <= n_a; r_b <= n_b; r_c <= n_c;
        r_d <= n_d; r_vert <= n_vert; r_horz <= n_horz; r_dxpos <= n_dxpos;
        r_ov <= n_ov; r_nf <= n_nf; r_out <= n_out;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flag <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flag <= n_flag;
            r_ovalid <= n_ovalid;
        end
    end

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n) (r_ovalid && i_stall) |=> $stable(r_out);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result word changed under stall");

    property p_take_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_q_take |-> (r_state == S_IDLE);
    endproperty
    a_take_idle: assert property (p_take_idle) else $error("word taken while busy");

    property p_flag_only_ok;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_flag != $past(r_flag)) |-> ($past(r_state) == S_CMP);
    endproperty
    a_flag_only_ok: assert property (p_flag_only_ok) else $error("flags changed outside finalize");
endmodule

// File: rtl/core/convex_frame_point_outside_test_core.sv
// Top level of the convex frame point outside test.
// A load or unused command has its answer set up in the result register when its word
// is taken from the queue; a finalize or query walks the edges through one shared fetch,
// subtract, multiply and compare sequence per step. A two-word queue in front and a
// result register behind let each side stall on its own. Up to two words are queued
// while one is in work.
module convex_frame_point_outside_test_core import cfpo_pkg::*; #(
    parameter int MAX_CORNERS = MAX_CORNERS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [3:0] i_cfg_data
);
    logic [3:0] r_corner_count;
    logic q_valid, q_take, busy;
    t_in_word q_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_corner_count <= 4'd0;
        else if (i_cfg_valid && o_cfg_ready) r_corner_count <= i_cfg_data;
    end

    cfpo_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_word(i_word), .o_q_valid(q_valid), .i_q_take(q_take), .o_q_word(q_word)
    );

    cfpo_back #(.MAX_CORNERS(MAX_CORNERS), .COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_corner_count(r_corner_count),
        .i_q_valid(q_valid), .o_q_take(q_take), .i_q_word(q_word),
        .o_valid(o_valid), .i_stall(i_stall), .o_word(o_word), .o_busy(busy)
    );

    property p_busy_when_queued;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> busy;
    endproperty
    a_busy_when_queued: assert property (p_busy_when_queued) else $error("result without busy");
endmodule
